@@ design/pxrc_pkg.sv @@
// Shared types and constants for the pixel row repeat-mask compactor.
// No dependencies; every design file imports this package.
package pxrc_pkg;

  localparam int ROW_PIXELS       = 256;
  localparam int LANES            = 8;
  localparam int PIXEL_W          = 32;
  localparam int ROW_GROUPS       = ROW_PIXELS / LANES;
  localparam int GROUPS_PER_BLOCK = 8;
  localparam int GIDX_W           = (ROW_GROUPS > 2) ? $clog2(ROW_GROUPS) : 1;
  localparam int POS_W            = $clog2(GROUPS_PER_BLOCK);
  localparam int MASK_W           = LANES * GROUPS_PER_BLOCK;
  localparam int COUNT_W          = 4;
  localparam int TOTAL_W          = 9;
  localparam int LANE_IDX_W       = $clog2(LANES);

  typedef logic [PIXEL_W-1:0]            pixel_t;
  typedef logic [LANES-1:0][PIXEL_W-1:0] pixel_vec_t;
  typedef logic [GIDX_W-1:0]             gidx_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [TOTAL_W-1:0]            total_t;

  // One result word as it sits in the output registers.
  typedef struct packed {
    pixel_vec_t          packed_px;
    count_t              kept_count;
    logic [MASK_W-1:0]   mask_word;
    logic                block_done;
    total_t              row_kept_total;
  } result_t;

endpackage

@@ design/pxrc_lane.sv @@
// One compare lane: flags a pixel that equals its predecessor in the row.
// Depends on pxrc_pkg.
module pxrc_lane
  import pxrc_pkg::*;
(
  input  pixel_t pixel,
  input  pixel_t prev_pixel,
  output logic   repeat_flag
);

  // A repeat is an exact match with the pixel before it.
  assign repeat_flag = (pixel == prev_pixel);

endmodule

@@ design/pxrc_merge.sv @@
// Merging stage: packs the kept pixels of all lanes into the low lanes.
// Depends on pxrc_pkg.
module pxrc_merge
  import pxrc_pkg::*;
(
  input  pixel_vec_t       pixels,
  input  logic [LANES-1:0] repeat_mask,
  output pixel_vec_t       packed_px,
  output count_t           kept_count
);

  count_t rank [LANES+1];

  // Rank of each lane among the kept pixels, as a running prefix count.
  always_comb begin
    rank[0] = '0;
    for (int i = 0; i < LANES; i++) begin
      rank[i+1] = rank[i] + count_t'(!repeat_mask[i]);
    end
  end

  assign kept_count = rank[LANES];

  // Each output lane takes the kept pixel whose rank matches it; unused lanes pad with pixel 0.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      packed_px[j] = pixels[0];
      for (int i = 0; i < LANES; i++) begin
        if (!repeat_mask[i] && (rank[i] == count_t'(j))) begin
          packed_px[j] = pixels[i];
        end
      end
    end
  end

endmodule

@@ design/pixel_row_repeat_mask_compactor.sv @@
// Top level of the pixel row repeat-mask compactor: row state, lanes, merge, output buffer.
// Depends on pxrc_pkg, pxrc_lane and pxrc_merge.
//
// Usage: each input word carries eight 32-bit pixels of a row plus row_start, on a
// valid/ready channel. Every word yields one output word with the packed kept pixels,
// kept_count, the running 64-bit repeat mask of the current block, block_done and the
// running count of kept pixels in the row.
// Each accepted word's result is registered. Throughput: one word per cycle while in_ready
// is high. The eight compare lanes, the merge and the row state update all settle in the
// accepting cycle, so nothing recirculates across words.
// A two-entry output buffer (main register plus skid register) lets a new word be taken
// while a finished result waits; in_ready drops only when both entries are full.
// Reset clears the row state (last pixel, block mask, group index, kept total) and both
// output valid flags; the first word after reset always begins a row.
// When the receiver stalls, results hold steady on the outputs and at most one more
// word is absorbed before in_ready goes low.
module pixel_row_repeat_mask_compactor
  import pxrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIXEL_W-1:0]  pixel_0,
  input  logic [PIXEL_W-1:0]  pixel_1,
  input  logic [PIXEL_W-1:0]  pixel_2,
  input  logic [PIXEL_W-1:0]  pixel_3,
  input  logic [PIXEL_W-1:0]  pixel_4,
  input  logic [PIXEL_W-1:0]  pixel_5,
  input  logic [PIXEL_W-1:0]  pixel_6,
  input  logic [PIXEL_W-1:0]  pixel_7,
  input  logic                row_start,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIXEL_W-1:0]  packed_0,
  output logic [PIXEL_W-1:0]  packed_1,
  output logic [PIXEL_W-1:0]  packed_2,
  output logic [PIXEL_W-1:0]  packed_3,
  output logic [PIXEL_W-1:0]  packed_4,
  output logic [PIXEL_W-1:0]  packed_5,
  output logic [PIXEL_W-1:0]  packed_6,
  output logic [PIXEL_W-1:0]  packed_7,
  output logic [COUNT_W-1:0]  kept_count,
  output logic [MASK_W-1:0]   mask_word,
  output logic                block_done,
  output logic [TOTAL_W-1:0]  row_kept_total
);

  // Row state.
  pixel_t            last_pixel;
  logic [MASK_W-1:0] block_mask;
  gidx_t             group_index;
  total_t            kept_total;

  // Output buffer.
  result_t main_res;
  result_t skid_res;
  logic    main_valid;
  logic    skid_valid;

  pixel_vec_t        pixels;
  logic              start;
  gidx_t             gidx_eff;
  logic [POS_W-1:0]  pos;
  pixel_t            prev [LANES];
  logic [LANES-1:0]  repeat_mask;
  pixel_vec_t        packed_px;
  count_t            group_kept;
  logic [MASK_W-1:0] block_mask_next;
  total_t            kept_total_next;
  logic              last_group;
  gidx_t             group_index_next;
  result_t           new_res;
  logic              in_fire;
  logic              out_fire;

  assign pixels = {pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};

  // A word begins a row on row_start or when the group index has wrapped.
  assign start    = row_start || (group_index == '0);
  assign gidx_eff = start ? '0 : group_index;
  assign pos      = gidx_eff[POS_W-1:0];

  // Predecessor of each lane: the previous lane, or for lane 0 the carried pixel (zero at a row start).
  always_comb begin
    prev[0] = start ? '0 : last_pixel;
    for (int i = 1; i < LANES; i++) begin
      prev[i] = pixels[i-1];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pxrc_lane u_lane (
      .pixel       (pixels[g]),
      .prev_pixel  (prev[g]),
      .repeat_flag (repeat_mask[g])
    );
  end

  pxrc_merge u_merge (
    .pixels      (pixels),
    .repeat_mask (repeat_mask),
    .packed_px   (packed_px),
    .kept_count  (group_kept)
  );

  // Block mask: this group's byte lands at its position, older bytes clear at block start.
  always_comb begin
    for (int b = 0; b < GROUPS_PER_BLOCK; b++) begin
      if (pos == POS_W'(b)) begin
        block_mask_next[b*LANES +: LANES] = repeat_mask;
      end else if (pos == '0) begin
        block_mask_next[b*LANES +: LANES] = '0;
      end else begin
        block_mask_next[b*LANES +: LANES] = block_mask[b*LANES +: LANES];
      end
    end
  end

  assign kept_total_next  = (start ? '0 : kept_total) + TOTAL_W'(group_kept);
  assign last_group       = (gidx_eff == GIDX_W'(ROW_GROUPS - 1));
  assign group_index_next = last_group ? '0 : gidx_eff + GIDX_W'(1);

  always_comb begin
    new_res.packed_px      = packed_px;
    new_res.kept_count     = group_kept;
    new_res.mask_word      = block_mask_next;
    new_res.block_done     = (pos == POS_W'(GROUPS_PER_BLOCK - 1)) || last_group;
    new_res.row_kept_total = kept_total_next;
  end

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = main_valid && out_ready;

  // Row state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pixel  <= '0;
      block_mask  <= '0;
      group_index <= '0;
      kept_total  <= '0;
    end else if (in_fire) begin
      last_pixel  <= pixels[LANES-1];
      block_mask  <= block_mask_next;
      group_index <= group_index_next;
      kept_total  <= kept_total_next;
    end
  end

  // Output buffer control: the skid entry fills only while the main entry is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_fire) begin
      main_valid <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (!main_valid || out_fire) begin
      main_res <= skid_valid ? skid_res : new_res;
    end else if (in_fire) begin
      skid_res <= new_res;
    end
  end

  assign out_valid      = main_valid;
  assign packed_0       = main_res.packed_px[0];
  assign packed_1       = main_res.packed_px[1];
  assign packed_2       = main_res.packed_px[2];
  assign packed_3       = main_res.packed_px[3];
  assign packed_4       = main_res.packed_px[4];
  assign packed_5       = main_res.packed_px[5];
  assign packed_6       = main_res.packed_px[6];
  assign packed_7       = main_res.packed_px[7];
  assign kept_count     = main_res.kept_count;
  assign mask_word      = main_res.mask_word;
  assign block_done     = main_res.block_done;
  assign row_kept_total = main_res.row_kept_total;

endmodule
